// ===== rtl/pbws_pkg.sv =====
// ----------------------------------------------------------------------------
// pbws_pkg: shared types and constants of the protobuf wire field scanner
// phases, result kinds, error codes, wire types and the result word layout
// ----------------------------------------------------------------------------
package pbws_pkg;

  // scanner phase
  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LEN,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  // result kinds
  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LEN_HDR = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_FIXED32 = 3'd4;
  localparam logic [2:0] KIND_END_OK  = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_BAD_WT    = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [63:0] FIXED64_BYTES    = 64'd8;
  localparam logic [63:0] FIXED32_BYTES    = 64'd4;
  localparam logic [3:0]  VARINT_MAX_BYTES = 4'd10;

  localparam logic [31:0] MATCH_FIELD_RESET = 32'd1;
  localparam int          RES_FIFO_DEPTH    = 4;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        is_match;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // scanner state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic [3:0]  vcnt;
    logic [31:0] fld;
    logic [2:0]  wt;
    logic [63:0] brem;
  } scan_state_t;

endpackage

// ===== rtl/pbws_step.sv =====
// ----------------------------------------------------------------------------
// pbws_step: next-state and result logic for one input byte
// decodes varints, counts fixed and payload bytes, builds up to two results
// ----------------------------------------------------------------------------
module pbws_step (
  input  pbws_pkg::scan_state_t st,
  input  logic [31:0]           match_field,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output pbws_pkg::scan_state_t nxt,
  output logic [1:0]            res_n,
  output pbws_pkg::result_t     res0,
  output pbws_pkg::result_t     res1
);

  typedef enum logic [1:0] {VR_MORE, VR_DONE, VR_LONG} vres_t;

  logic [6:0]         sh7;
  logic               sh_over;
  logic [63:0]        acc_or;
  logic [3:0]         vcnt_inc;
  vres_t              vres;
  logic [63:0]        brem_dec;
  logic               brem_zero;
  logic               match;
  logic               prim_v;
  pbws_pkg::result_t  prim;
  logic               fail_v;
  logic [1:0]         fail_code;
  logic               done;
  logic               end_v;
  pbws_pkg::result_t  fail_res;
  pbws_pkg::result_t  end_res;

  always_comb begin
    // varint byte feed
    sh7      = {st.vcnt, 3'b000} - {3'b000, st.vcnt};
    sh_over  = sh7 > 7'd63;
    acc_or   = st.acc | ({57'd0, data_byte[6:0]} << sh7);
    vcnt_inc = st.vcnt + 4'd1;
    if (sh_over) begin
      vres = VR_LONG;
    end else if (!data_byte[7]) begin
      vres = VR_DONE;
    end else if (vcnt_inc >= pbws_pkg::VARINT_MAX_BYTES) begin
      vres = VR_LONG;
    end else begin
      vres = VR_MORE;
    end

    brem_dec  = st.brem - 64'd1;
    brem_zero = (brem_dec == 64'd0);
    match     = (st.fld == match_field) && (st.wt == pbws_pkg::WT_LEN);

    nxt       = st;
    prim_v    = 1'b0;
    prim      = '0;
    fail_v    = 1'b0;
    fail_code = pbws_pkg::ERR_NONE;
    done      = 1'b0;

    case (st.phase)
      pbws_pkg::PH_TAG: begin
        if (!sh_over) begin
          nxt.acc  = acc_or;
          nxt.vcnt = vcnt_inc;
        end
        case (vres)
          VR_LONG: begin
            fail_v    = 1'b1;
            fail_code = pbws_pkg::ERR_TOO_LONG;
          end
          VR_MORE: begin
            if (last_byte) begin
              fail_v    = 1'b1;
              fail_code = pbws_pkg::ERR_TRUNCATED;
            end
          end
          default: begin
            nxt.fld  = acc_or[34:3];
            nxt.wt   = acc_or[2:0];
            nxt.acc  = '0;
            nxt.vcnt = '0;
            case (acc_or[2:0])
              pbws_pkg::WT_VARINT: nxt.phase = pbws_pkg::PH_VARINT;
              pbws_pkg::WT_FIXED64: begin
                nxt.phase = pbws_pkg::PH_FIXED;
                nxt.brem  = pbws_pkg::FIXED64_BYTES;
              end
              pbws_pkg::WT_FIXED32: begin
                nxt.phase = pbws_pkg::PH_FIXED;
                nxt.brem  = pbws_pkg::FIXED32_BYTES;
              end
              pbws_pkg::WT_LEN: nxt.phase = pbws_pkg::PH_LEN;
              default: begin
                fail_v    = 1'b1;
                fail_code = pbws_pkg::ERR_BAD_WT;
              end
            endcase
            if (!fail_v && last_byte) begin
              fail_v    = 1'b1;
              fail_code = pbws_pkg::ERR_TRUNCATED;
            end
          end
        endcase
      end
      pbws_pkg::PH_VARINT: begin
        if (!sh_over) begin
          nxt.acc  = acc_or;
          nxt.vcnt = vcnt_inc;
        end
        case (vres)
          VR_LONG: begin
            fail_v    = 1'b1;
            fail_code = pbws_pkg::ERR_TOO_LONG;
          end
          VR_MORE: begin
            if (last_byte) begin
              fail_v    = 1'b1;
              fail_code = pbws_pkg::ERR_TRUNCATED;
            end
          end
          default: begin
            prim_v            = 1'b1;
            prim.kind         = pbws_pkg::KIND_VARINT;
            prim.field_number = st.fld;
            prim.wtype        = st.wt;
            prim.value        = acc_or;
            done              = 1'b1;
          end
        endcase
      end
      pbws_pkg::PH_FIXED: begin
        nxt.brem = brem_dec;
        if (brem_zero) begin
          prim_v            = 1'b1;
          prim.kind         = (st.wt == pbws_pkg::WT_FIXED64) ? pbws_pkg::KIND_FIXED64
                                                               : pbws_pkg::KIND_FIXED32;
          prim.field_number = st.fld;
          prim.wtype        = st.wt;
          done              = 1'b1;
        end else if (last_byte) begin
          fail_v    = 1'b1;
          fail_code = pbws_pkg::ERR_TRUNCATED;
        end
      end
      pbws_pkg::PH_LEN: begin
        if (!sh_over) begin
          nxt.acc  = acc_or;
          nxt.vcnt = vcnt_inc;
        end
        case (vres)
          VR_LONG: begin
            fail_v    = 1'b1;
            fail_code = pbws_pkg::ERR_TOO_LONG;
          end
          VR_MORE: begin
            if (last_byte) begin
              fail_v    = 1'b1;
              fail_code = pbws_pkg::ERR_TRUNCATED;
            end
          end
          default: begin
            prim_v            = 1'b1;
            prim.kind         = pbws_pkg::KIND_LEN_HDR;
            prim.field_number = st.fld;
            prim.wtype        = st.wt;
            prim.value        = acc_or;
            prim.is_match     = match;
            if (acc_or == 64'd0) begin
              done = 1'b1;
            end else begin
              nxt.brem  = acc_or;
              nxt.phase = pbws_pkg::PH_PAYLOAD;
              if (last_byte) begin
                fail_v    = 1'b1;
                fail_code = pbws_pkg::ERR_TRUNCATED;
              end
            end
          end
        endcase
      end
      pbws_pkg::PH_PAYLOAD: begin
        prim_v            = 1'b1;
        prim.kind         = pbws_pkg::KIND_PAYLOAD;
        prim.field_number = st.fld;
        prim.wtype        = st.wt;
        prim.value        = st.acc;
        prim.payload_byte = data_byte;
        prim.is_match     = match;
        nxt.brem          = brem_dec;
        if (brem_zero) begin
          done = 1'b1;
        end else if (last_byte) begin
          fail_v    = 1'b1;
          fail_code = pbws_pkg::ERR_TRUNCATED;
        end
      end
      default: begin
        // discarding until end of message
      end
    endcase

    end_v = done && last_byte;
    if (done) begin
      nxt.phase = pbws_pkg::PH_TAG;
      nxt.acc   = '0;
      nxt.vcnt  = '0;
    end
    if (fail_v) begin
      nxt.phase = pbws_pkg::PH_DISCARD;
    end
    if (last_byte) begin
      nxt.phase = pbws_pkg::PH_TAG;
      nxt.acc   = '0;
      nxt.vcnt  = '0;
      nxt.fld   = '0;
      nxt.wt    = '0;
      nxt.brem  = '0;
    end

    fail_res            = '0;
    fail_res.kind       = pbws_pkg::KIND_ERROR;
    fail_res.error_code = fail_code;
    end_res             = '0;
    end_res.kind        = pbws_pkg::KIND_END_OK;

    // order: field result, then error or end marker
    res0 = '0;
    res1 = '0;
    if (prim_v) begin
      res0 = prim;
      if (fail_v || end_v) begin
        res_n = 2'd2;
        res1  = fail_v ? fail_res : end_res;
        res1.last_of_run = 1'b1;
      end else begin
        res_n = 2'd1;
        res0.last_of_run = 1'b1;
      end
    end else if (fail_v) begin
      res_n = 2'd1;
      res0  = fail_res;
      res0.last_of_run = 1'b1;
    end else begin
      res_n = 2'd0;
    end
  end

endmodule

// ===== rtl/pbws_res_fifo.sv =====
// ----------------------------------------------------------------------------
// pbws_res_fifo: small result queue
// takes zero, one or two words per cycle, hands out one
// ----------------------------------------------------------------------------
module pbws_res_fifo #(
  parameter int DEPTH = pbws_pkg::RES_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  pbws_pkg::result_t push0,
  input  pbws_pkg::result_t push1,
  input  logic              pop,
  output pbws_pkg::result_t head,
  output logic              not_empty,
  output logic              no_room
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_LIM = CW'(DEPTH - 1);

  pbws_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_p1;
  logic [PW-1:0] wr_p2;

  always_comb begin
    wr_p1 = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    wr_p2 = (wr_p1 == LAST_IDX) ? '0 : wr_p1 + PW'(1);
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_p1;
      2'd2:    wr_ptr_nxt = wr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign no_room   = (cnt_r >= ROOM_LIM);

endmodule

// ===== rtl/protobuf_wire_field_scanner_core.sv =====
// ----------------------------------------------------------------------------
// protobuf_wire_field_scanner_core: protobuf wire-format field scanner
// results: written into the result queue when their byte is taken, offered from its head
// throughput: one byte per cycle while results drain and the queue has room for two words
// reset: synchronous active-low, expecting a tag, match_field back to one
// ----------------------------------------------------------------------------
module protobuf_wire_field_scanner_core #(
  parameter int RES_FIFO_DEPTH = pbws_pkg::RES_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_field_number,
  output logic [2:0]  out_wire_type,
  output logic [63:0] out_value,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_match,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  // byte handshake: a byte is taken when valid and the queue has room for
  // the worst case of two result words
  logic in_accept;
  logic out_accept;

  // configured field number to flag on length-delimited fields
  logic [31:0] match_field_r;

  // scanner state, advanced once per accepted byte
  pbws_pkg::scan_state_t st_r, st_nxt;

  // results produced by the current byte
  logic [1:0]        res_n;
  pbws_pkg::result_t res0;
  pbws_pkg::result_t res1;
  pbws_pkg::result_t head;
  logic              no_room;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = no_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_field_r <= pbws_pkg::MATCH_FIELD_RESET;
    end else if (cfg_wr_en) begin
      match_field_r <= cfg_wr_data;
    end
  end

  // decode one byte: tag split, varint build, byte counting, error checks
  pbws_step u_step (
    .st          (st_r),
    .match_field (match_field_r),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .nxt         (st_nxt),
    .res_n       (res_n),
    .res0        (res0),
    .res1        (res1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= pbws_pkg::PH_TAG;
      st_r.acc   <= '0;
      st_r.vcnt  <= '0;
      st_r.fld   <= '0;
      st_r.wt    <= '0;
      st_r.brem  <= '0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // result queue decouples the byte side from the result side
  pbws_res_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (in_accept ? res_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_accept),
    .head      (head),
    .not_empty (out_valid),
    .no_room   (no_room)
  );

  // result word fields
  assign out_kind         = head.kind;
  assign out_field_number = head.field_number;
  assign out_wire_type    = head.wtype;
  assign out_value        = head.value;
  assign out_payload_byte = head.payload_byte;
  assign out_is_match     = head.is_match;
  assign out_error_code   = head.error_code;
  assign out_last_of_run  = head.last_of_run;

endmodule
